// ===== hw/rtl/avp_pkg.sv =====
package avp_pkg;

  localparam int REQ_W   = 1;
  localparam int ROW_W   = 7;
  localparam int COL_W   = 6;
  localparam int WGT_W   = 16;
  localparam int FEAT_W  = 16;
  localparam int CFG_W   = 7;
  localparam int PROD_W  = FEAT_W + WGT_W;
  localparam int ACC_W   = 48;
  localparam int OUT_W   = 32;

  // At most this many results per vector
  localparam int RESULT_LIMIT = 64;

  // The constant 1 in Q8.8 is 256: the bias term is the weight shifted left by 8
  localparam int ONE_SHIFT = 8;

  // Q.20 accumulator to Q16.16 output: add half an LSB, drop four bits
  localparam int FRAC_DROP  = 4;
  localparam int ROUND_HALF = 8;

  localparam logic [REQ_W-1:0] REQ_WEIGHT  = 1'b0;
  localparam logic [REQ_W-1:0] REQ_FEATURE = 1'b1;

  typedef struct packed {
    logic             w_write;
    logic             f_latch;
    logic             row_first;
    logic             row_next;
    logic             mac_issue;
    logic             mac_bias;
    logic             emit_load;
    logic             emit_last;
    logic             emit_too_long;
    logic [COL_W-1:0] col;
  } avp_cmd_t;

  typedef struct packed {
    logic out_free;
  } avp_sts_t;

endpackage

// ===== hw/rtl/avp_feed_if.sv =====
interface avp_feed_if;
  import avp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [ROW_W-1:0]         weight_row;
  logic [COL_W-1:0]         weight_col;
  logic signed [WGT_W-1:0]  weight_value;
  logic signed [FEAT_W-1:0] feature_value;
  logic                     feature_last;

  modport source (
    output valid, req_type, weight_row, weight_col, weight_value, feature_value,
           feature_last,
    input  ready
  );

  modport sink (
    input  valid, req_type, weight_row, weight_col, weight_value, feature_value,
           feature_last,
    output ready
  );

endinterface

// ===== hw/rtl/avp_result_if.sv =====
interface avp_result_if;
  import avp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_value;
  logic [COL_W-1:0]        out_index;
  logic                    out_last;
  logic                    saturated;
  logic                    too_long;

  modport source (
    output valid, out_value, out_index, out_last, saturated, too_long,
    input  ready
  );

  modport sink (
    input  valid, out_value, out_index, out_last, saturated, too_long,
    output ready
  );

endinterface

// ===== hw/rtl/avp_ctrl.sv =====
module avp_ctrl #(
  parameter int MAX_IN  = 64,
  parameter int MAX_OUT = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [avp_pkg::REQ_W-1:0]  req_type,
  input  logic                       feature_last,
  input  logic                       cfg_we,
  input  logic [avp_pkg::CFG_W-1:0]  cfg_data,
  output avp_pkg::avp_cmd_t          cmd,
  input  avp_pkg::avp_sts_t          sts
);
  import avp_pkg::*;

  localparam int NCOL  = (MAX_OUT < RESULT_LIMIT) ? MAX_OUT : RESULT_LIMIT;
  localparam int CNT_W = $clog2(MAX_IN + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_BIAS    = 3'd1;
  localparam logic [2:0] S_ELEM    = 3'd2;
  localparam logic [2:0] S_MAC     = 3'd3;
  localparam logic [2:0] S_DRAIN   = 3'd4;
  localparam logic [2:0] S_EMIT_RD = 3'd5;
  localparam logic [2:0] S_EMIT_WR = 3'd6;

  logic [2:0]       state, state_next;
  logic [COL_W-1:0] col, col_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             ovf, ovf_next;
  logic             open, open_next;
  logic             last, last_next;
  logic             from_bias, from_bias_next;
  logic             drain, drain_next;
  logic [CFG_W-1:0] out_dim;

  logic [CFG_W-1:0] n_emit;
  logic [COL_W-1:0] n_last;
  logic             col_end;

  // Clamp the column count to one at least and to the columns kept
  always_comb begin
    if (out_dim == '0) begin
      n_emit = CFG_W'(1);
    end else if (out_dim > CFG_W'(NCOL)) begin
      n_emit = CFG_W'(NCOL);
    end else begin
      n_emit = out_dim;
    end
    n_last  = COL_W'(n_emit - CFG_W'(1));
    col_end = (col == COL_W'(NCOL - 1));
  end

  always_comb begin
    state_next     = state;
    col_next       = col;
    cnt_next       = cnt;
    ovf_next       = ovf;
    open_next      = open;
    last_next      = last;
    from_bias_next = from_bias;
    drain_next     = drain;
    cmd            = '0;
    cmd.col        = col;
    in_ready       = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_WEIGHT) begin
            cmd.w_write = 1'b1;
          end else begin
            cmd.f_latch = 1'b1;
            last_next   = feature_last;
            if (!open) begin
              open_next     = 1'b1;
              cnt_next      = '0;
              ovf_next      = 1'b0;
              cmd.row_first = 1'b1;
              col_next      = '0;
              state_next    = S_BIAS;
            end else begin
              state_next = S_ELEM;
            end
          end
        end
      end

      S_BIAS: begin
        cmd.mac_issue = 1'b1;
        cmd.mac_bias  = 1'b1;
        if (col_end) begin
          col_next       = '0;
          from_bias_next = 1'b1;
          drain_next     = 1'b0;
          state_next     = S_DRAIN;
        end else begin
          col_next = col + COL_W'(1);
        end
      end

      S_ELEM: begin
        col_next = '0;
        if (cnt < CNT_W'(MAX_IN)) begin
          cnt_next   = cnt + CNT_W'(1);
          state_next = S_MAC;
        end else begin
          // Drop the element, remember the vector ran long
          ovf_next   = 1'b1;
          state_next = last ? S_EMIT_RD : S_IDLE;
        end
      end

      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (col_end) begin
          cmd.row_next   = 1'b1;
          col_next       = '0;
          from_bias_next = 1'b0;
          drain_next     = 1'b0;
          state_next     = S_DRAIN;
        end else begin
          col_next = col + COL_W'(1);
        end
      end

      S_DRAIN: begin
        drain_next = 1'b1;
        if (drain) begin
          col_next = '0;
          if (from_bias) begin
            state_next = S_ELEM;
          end else if (last) begin
            state_next = S_EMIT_RD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      S_EMIT_RD: begin
        state_next = S_EMIT_WR;
      end

      S_EMIT_WR: begin
        if (sts.out_free) begin
          cmd.emit_load     = 1'b1;
          cmd.emit_last     = (col == n_last);
          cmd.emit_too_long = ovf;
          if (col == n_last) begin
            open_next  = 1'b0;
            cnt_next   = '0;
            ovf_next   = 1'b0;
            col_next   = '0;
            state_next = S_IDLE;
          end else begin
            col_next   = col + COL_W'(1);
            state_next = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col       <= '0;
      cnt       <= '0;
      ovf       <= 1'b0;
      open      <= 1'b0;
      last      <= 1'b0;
      from_bias <= 1'b0;
      drain     <= 1'b0;
      out_dim   <= CFG_W'(1);
    end else begin
      state     <= state_next;
      col       <= col_next;
      cnt       <= cnt_next;
      ovf       <= ovf_next;
      open      <= open_next;
      last      <= last_next;
      from_bias <= from_bias_next;
      drain     <= drain_next;
      if (cfg_we) begin
        out_dim <= cfg_data;
      end
    end
  end

endmodule

// ===== hw/rtl/avp_datapath.sv =====
module avp_datapath #(
  parameter int MAX_IN  = 64,
  parameter int MAX_OUT = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [avp_pkg::ROW_W-1:0]         weight_row,
  input  logic [avp_pkg::COL_W-1:0]         weight_col,
  input  logic signed [avp_pkg::WGT_W-1:0]  weight_value,
  input  logic signed [avp_pkg::FEAT_W-1:0] feature_value,
  input  avp_pkg::avp_cmd_t                 cmd,
  output avp_pkg::avp_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [avp_pkg::OUT_W-1:0]  out_value,
  output logic [avp_pkg::COL_W-1:0]         out_index,
  output logic                              out_last,
  output logic                              saturated,
  output logic                              too_long
);
  import avp_pkg::*;

  localparam int NCOL   = (MAX_OUT < RESULT_LIMIT) ? MAX_OUT : RESULT_LIMIT;
  localparam int WDEPTH = (MAX_IN + 1) * MAX_OUT;
  localparam int WA_W   = $clog2(WDEPTH);
  localparam int AI_W   = (NCOL > 1) ? $clog2(NCOL) : 1;
  localparam int Q_W    = ACC_W + 1 - FRAC_DROP;

  // Weight store and accumulator file
  logic [WGT_W-1:0]        wmem [WDEPTH];
  logic signed [ACC_W-1:0] amem [NCOL];

  logic [WA_W-1:0]          row_base;
  logic [WA_W-1:0]          w_waddr, w_raddr;
  logic                     w_we;
  logic signed [WGT_W-1:0]  w_rdata;
  logic signed [ACC_W-1:0]  a_rdata;
  logic signed [FEAT_W-1:0] feat;

  logic                     s1_v, s1_bias;
  logic [AI_W-1:0]          s1_col;
  logic                     s2_v;
  logic [AI_W-1:0]          s2_col;
  logic signed [PROD_W-1:0] s2_prod;
  logic signed [ACC_W-1:0]  s2_add;

  logic signed [ACC_W:0]    rnd;
  logic signed [Q_W-1:0]    q;
  logic [Q_W-OUT_W:0]       q_hi;
  logic                     q_sat;
  logic signed [OUT_W-1:0]  q_val;

  always_comb begin
    w_we    = cmd.w_write && (int'(weight_row) <= MAX_IN) && (int'(weight_col) < MAX_OUT);
    w_waddr = WA_W'(weight_row) * WA_W'(MAX_OUT) + WA_W'(weight_col);
    w_raddr = cmd.mac_bias ? WA_W'(cmd.col) : row_base + WA_W'(cmd.col);
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= weight_value;
    end
    w_rdata <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (s2_v) begin
      amem[s2_col] <= s2_add + {{(ACC_W - PROD_W){s2_prod[PROD_W-1]}}, s2_prod};
    end
    a_rdata <= amem[cmd.col[AI_W-1:0]];
  end

  // Row base walks one row of the store per element
  always_ff @(posedge clk) begin
    if (cmd.row_first) begin
      row_base <= WA_W'(MAX_OUT);
    end else if (cmd.row_next) begin
      row_base <= row_base + WA_W'(MAX_OUT);
    end
    if (cmd.f_latch) begin
      feat <= feature_value;
    end
  end

  // Multiply stage, then accumulate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= cmd.mac_issue;
      s2_v <= s1_v;
    end
    s1_bias <= cmd.mac_bias;
    s1_col  <= cmd.col[AI_W-1:0];
    s2_col  <= s1_col;
    if (s1_bias) begin
      s2_prod <= {{(PROD_W - WGT_W - ONE_SHIFT){w_rdata[WGT_W-1]}}, w_rdata,
                  {ONE_SHIFT{1'b0}}};
      s2_add  <= '0;
    end else begin
      s2_prod <= feat * w_rdata;
      s2_add  <= a_rdata;
    end
  end

  // Round to nearest, ties up, then clip to the output range
  always_comb begin
    rnd   = {a_rdata[ACC_W-1], a_rdata} + (ACC_W + 1)'(ROUND_HALF);
    q     = rnd[ACC_W:FRAC_DROP];
    q_hi  = q[Q_W-1:OUT_W-1];
    q_sat = !((&q_hi) || !(|q_hi));
    if (q_sat) begin
      q_val = q[Q_W-1] ? {1'b1, {(OUT_W - 1){1'b0}}} : {1'b0, {(OUT_W - 1){1'b1}}};
    end else begin
      q_val = q[OUT_W-1:0];
    end
  end

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit_load) begin
      out_value <= q_val;
      out_index <= cmd.col;
      out_last  <= cmd.emit_last;
      saturated <= q_sat;
      too_long  <= cmd.emit_too_long;
    end
  end

endmodule

// ===== hw/rtl/affine_vector_projection_core.sv =====
// Affine vector projection: a fully connected layer with bias.
// feed carries one word per handshake: req_type 0 writes one Q4.12 weight at
// (weight_row, weight_col), row 0 being the bias row; req_type 1 brings one
// Q8.8 feature element, feature_last closing the vector. result carries one
// Q16.16 component per word, clipped to 32 bits, with its column, a last mark,
// a clip flag and a flag for vectors longer than MAX_IN (extra elements drop).
// cfg_we/cfg_data set out_dim, the columns emitted per vector (reset value 1).
// Operation, with C = min(MAX_OUT, 64) accumulated columns:
//   weight word      written to the store as it is taken;
//   feature element  walks all C columns, one column per cycle through the
//                    single shared multiply-accumulate and the accumulator
//                    file; the first element of a vector first loads the
//                    bias row the same way;
//   closing element  then each result in turn, the accumulator read and the
//                    rounding stage taking turns.
// Reset clears the control and empties the result register; the weight store
// keeps no reset value and must be written before use. A stalled receiver
// holds the result register and halts the emission; once the last result is
// registered, feed is taken again while that word waits.
module affine_vector_projection_core #(
  parameter int MAX_IN  = 64,
  parameter int MAX_OUT = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  avp_feed_if.sink                  feed,
  avp_result_if.source              result,
  input  logic                      cfg_we,
  input  logic [avp_pkg::CFG_W-1:0] cfg_data
);
  import avp_pkg::*;

  avp_cmd_t cmd;
  avp_sts_t sts;

  // Sequence bias, element and emission passes
  avp_ctrl #(
    .MAX_IN  (MAX_IN),
    .MAX_OUT (MAX_OUT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (feed.valid),
    .in_ready     (feed.ready),
    .req_type     (feed.req_type),
    .feature_last (feed.feature_last),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts)
  );

  // Hold weights and accumulators, run the MAC and drive the result word
  avp_datapath #(
    .MAX_IN  (MAX_IN),
    .MAX_OUT (MAX_OUT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .weight_row    (feed.weight_row),
    .weight_col    (feed.weight_col),
    .weight_value  (feed.weight_value),
    .feature_value (feed.feature_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_value     (result.out_value),
    .out_index     (result.out_index),
    .out_last      (result.out_last),
    .saturated     (result.saturated),
    .too_long      (result.too_long)
  );

endmodule
